// ===== src/cartesian_to_range_azimuth_elevation_unit_assert.svh =====
// Assertion macros shared by the range, azimuth and elevation unit.
`ifndef CARTESIAN_TO_RANGE_AZIMUTH_ELEVATION_UNIT_ASSERT_SVH
`define CARTESIAN_TO_RANGE_AZIMUTH_ELEVATION_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define CRAE_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define CRAE_ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define CRAE_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== src/crae_pkg.sv =====
// Shared types, constants and the arctangent table of the range and angle unit.
package crae_pkg;

   // Width of the CORDIC datapath: a 32-bit value scaled by 2^24 plus growth.
   localparam int CORDIC_W = 60;

   // Number of entries in the arctangent table.
   localparam int MAX_CORDIC = 40;

   // Degree units (1/65536 degree) in a full turn and in a quarter turn.
   localparam logic [24:0] DEG_UNITS  = 25'd23592960;
   localparam logic [24:0] ELEV_LIMIT = 25'd5898240;

   // Output limits of the elevation.
   localparam logic signed [23:0] EL_MAX = 24'sd5898240;
   localparam logic signed [23:0] EL_MIN = -24'sd5898240;

   // Half an output step in the 2^-32 scaled product.
   localparam logic [57:0] HALF_STEP = 58'h0_0000_8000_0000;

   // Binary angle of half a turn.
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   // Flags and the slant range carried alongside the datapath.
   typedef struct packed {
      logic        h_zero;
      logic        s_zero;
      logic        u_neg;
      logic [31:0] range;
   } side_type;

   // Normalised offsets waiting for the square roots.
   typedef struct packed {
      logic signed [31:0] east;
      logic signed [31:0] north;
      logic signed [31:0] up;
   } hold_type;

   // One finished result.
   typedef struct packed {
      logic [31:0]        range;
      logic [24:0]        azimuth;
      logic signed [23:0] elevation;
      logic               origin;
   } result_type;

   // atan(2^-i) as a binary angle (2^32 is a full turn), rounded to nearest.
   function automatic logic [31:0] atan_bam(input int idx);
      logic [31:0] val;
      case (idx)
         0:  val = 32'd536870912;
         1:  val = 32'd316933406;
         2:  val = 32'd167458907;
         3:  val = 32'd85004756;
         4:  val = 32'd42667331;
         5:  val = 32'd21354465;
         6:  val = 32'd10680862;
         7:  val = 32'd5340245;
         8:  val = 32'd2670163;
         9:  val = 32'd1335087;
         10: val = 32'd667544;
         11: val = 32'd333772;
         12: val = 32'd166886;
         13: val = 32'd83443;
         14: val = 32'd41722;
         15: val = 32'd20861;
         16: val = 32'd10430;
         17: val = 32'd5215;
         18: val = 32'd2608;
         19: val = 32'd1304;
         20: val = 32'd652;
         21: val = 32'd326;
         22: val = 32'd163;
         23: val = 32'd81;
         24: val = 32'd41;
         25: val = 32'd20;
         26: val = 32'd10;
         27: val = 32'd5;
         28: val = 32'd3;
         29: val = 32'd1;
         30: val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== src/cartesian_to_range_azimuth_elevation_unit.sv =====
// Top level: east, north, up offset to slant range, azimuth and elevation.
//
// Takes one transaction per clock while req_stall is low, and gives one result per
// transaction, in order. The pipeline is made of the squares, their sums, the
// five-step normalising shift, the two 32-cell square-root chains, the CORDIC
// cell chains and the angle conversion registers. A result that waits on
// rsp_stall is held in the output register, and one more finished transaction is
// caught in a skid register behind it; the pipeline, and req_stall, stop only once
// that skid register is full. Angles are in units of 1/65536 degree; the azimuth is
// zero when east and north are both zero, and at_origin marks a zero range.
module cartesian_to_range_azimuth_elevation_unit #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_east_cm,
   input  logic signed [31:0] req_north_cm,
   input  logic signed [31:0] req_up_cm,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_range_cm,
   output logic [24:0]        rsp_azimuth_angle,
   output logic signed [23:0] rsp_elevation_angle,
   output logic               rsp_at_origin
);

   `include "cartesian_to_range_azimuth_elevation_unit_assert.svh"

   localparam int W        = crae_pkg::CORDIC_W;
   localparam int NC       = (CORDIC_STAGES > crae_pkg::MAX_CORDIC) ?
                             crae_pkg::MAX_CORDIC : CORDIC_STAGES;
   localparam int ST_PREP  = 39;
   localparam int NUM_ST   = 42 + NC;

   // Pipeline control.
   logic                      en;
   logic [NUM_ST-1:0]         valid_in, valid_ff;
   crae_pkg::side_type        side_in [0:NUM_ST-1];
   crae_pkg::side_type        side_ff [0:NUM_ST-1];

   // Stage 0: squares.
   logic signed [63:0]        e_sq, n_sq, u_sq;
   logic signed [31:0]        e0_ff, n0_ff, u0_ff;
   logic [62:0]               e2_ff, n2_ff, u2_ff;

   // Stage 1: sums of squares.
   logic [63:0]               h2_in, s2_in, h2_ff, s2_ff;
   logic signed [31:0]        e1_ff, n1_ff, u1_ff;

   // Normalising chains and the raw radicand beside them.
   logic [63:0]               nh_sq [0:5];
   logic signed [31:0]        nh_a  [0:5];
   logic [31:0]               nh_b  [0:5];
   logic [63:0]               ns_sq [0:5];
   logic signed [31:0]        ns_a  [0:5];
   logic [63:0]               ns_b  [0:5];
   logic [63:0]               raw_in [0:4];
   logic [63:0]               raw_ff [0:4];

   // Square-root chains and the offsets that wait beside them.
   logic [63:0]               ra_rad  [0:32];
   logic [32:0]               ra_rem  [0:32];
   logic [31:0]               ra_root [0:32];
   logic [63:0]               rb_rad  [0:32];
   logic [32:0]               rb_rem  [0:32];
   logic [31:0]               rb_root [0:32];
   crae_pkg::hold_type        hold_in [0:31];
   crae_pkg::hold_type        hold_ff [0:31];

   // CORDIC chains.
   logic signed [W-1:0]       az_x [0:NC];
   logic signed [W-1:0]       az_y [0:NC];
   logic [31:0]               az_z [0:NC];
   logic signed [W-1:0]       el_x [0:NC];
   logic signed [W-1:0]       el_y [0:NC];
   logic [31:0]               el_z [0:NC];
   logic signed [W-1:0]       pn_x, pe_y;
   logic signed [W-1:0]       az_x_in, az_y_in, el_x_in, el_y_in;
   logic signed [W-1:0]       az_x_ff, az_y_ff, el_x_ff, el_y_ff;
   logic [31:0]               az_z_in, az_z_ff;
   logic                      flip;

   // Angle conversion.
   logic [31:0]               abs_az_ff, abs_el_ff, abs_el_in;
   logic                      abs_neg_ff, mul_neg_ff;
   logic [56:0]               mul_az_in, mul_el_in, mul_az_ff, mul_el_ff;
   logic [57:0]               az_round, el_round;
   logic [24:0]               az_val, el_m, el_cap;
   logic signed [23:0]        el_val;
   crae_pkg::result_type      res;

   // Output register and skid register.
   logic                      tail_fire, out_free;
   logic                      out_v_in, out_v_ff, skid_v_in, skid_v_ff;
   crae_pkg::result_type      out_d_in, out_d_ff, skid_d_in, skid_d_ff;

   // The whole pipeline moves unless the skid register is occupied.
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;
   assign valid_in  = {valid_ff[NUM_ST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // Flags travel with each transaction; the range joins after the square root.
   always_comb begin
      side_in[0].h_zero = (req_east_cm == '0) && (req_north_cm == '0);
      side_in[0].s_zero = side_in[0].h_zero && (req_up_cm == '0);
      side_in[0].u_neg  = req_up_cm[31];
      side_in[0].range  = '0;
      for (int s = 1; s < NUM_ST; s++) begin
         side_in[s] = side_ff[s-1];
      end
      side_in[ST_PREP].range = ra_root[32];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NUM_ST; s++) begin
            side_ff[s] <= side_in[s];
         end
      end
   end

   // Squares of the three offsets.
   assign e_sq = req_east_cm * req_east_cm;
   assign n_sq = req_north_cm * req_north_cm;
   assign u_sq = req_up_cm * req_up_cm;

   always_ff @(posedge clock) begin
      if (en) begin
         e0_ff <= req_east_cm;
         n0_ff <= req_north_cm;
         u0_ff <= req_up_cm;
         e2_ff <= e_sq[62:0];
         n2_ff <= n_sq[62:0];
         u2_ff <= u_sq[62:0];
      end
   end

   // Horizontal and slant squared lengths.
   assign h2_in = {1'b0, e2_ff} + {1'b0, n2_ff};
   assign s2_in = {1'b0, e2_ff} + {1'b0, n2_ff} + {1'b0, u2_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         h2_ff <= h2_in;
         s2_ff <= s2_in;
         e1_ff <= e0_ff;
         n1_ff <= n0_ff;
         u1_ff <= u0_ff;
      end
   end

   // Normalising shifts: by 16, 8, 4, 2 and 1 bit pairs.
   assign nh_sq[0] = h2_ff;
   assign nh_a[0]  = e1_ff;
   assign nh_b[0]  = n1_ff;
   assign ns_sq[0] = s2_ff;
   assign ns_a[0]  = u1_ff;
   assign ns_b[0]  = h2_ff;

   for (genvar j = 0; j < 5; j++) begin : g_norm
      crae_norm_cell #(.PAIRS(16 >> j), .B_W(32), .B_SCALE(1)) u_norm_h (
         .clock (clock),
         .en    (en),
         .sq_i  (nh_sq[j]),
         .a_i   (nh_a[j]),
         .b_i   (nh_b[j]),
         .sq_o  (nh_sq[j+1]),
         .a_o   (nh_a[j+1]),
         .b_o   (nh_b[j+1])
      );
      crae_norm_cell #(.PAIRS(16 >> j), .B_W(64), .B_SCALE(2)) u_norm_s (
         .clock (clock),
         .en    (en),
         .sq_i  (ns_sq[j]),
         .a_i   (ns_a[j]),
         .b_i   (ns_b[j]),
         .sq_o  (ns_sq[j+1]),
         .a_o   (ns_a[j+1]),
         .b_o   (ns_b[j+1])
      );
   end

   // The unshifted slant square waits beside the normalising chains.
   always_comb begin
      raw_in[0] = s2_ff;
      for (int k = 1; k < 5; k++) begin
         raw_in[k] = raw_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 5; k++) begin
            raw_ff[k] <= raw_in[k];
         end
      end
   end

   // Square roots: slant range, and the scaled horizontal length.
   assign ra_rad[0]  = raw_ff[4];
   assign ra_rem[0]  = '0;
   assign ra_root[0] = '0;
   assign rb_rad[0]  = ns_b[5];
   assign rb_rem[0]  = '0;
   assign rb_root[0] = '0;

   for (genvar j = 0; j < 32; j++) begin : g_sqrt
      crae_sqrt_cell u_sqrt_a (
         .clock  (clock),
         .en     (en),
         .rad_i  (ra_rad[j]),
         .rem_i  (ra_rem[j]),
         .root_i (ra_root[j]),
         .rad_o  (ra_rad[j+1]),
         .rem_o  (ra_rem[j+1]),
         .root_o (ra_root[j+1])
      );
      crae_sqrt_cell u_sqrt_b (
         .clock  (clock),
         .en     (en),
         .rad_i  (rb_rad[j]),
         .rem_i  (rb_rem[j]),
         .root_i (rb_root[j]),
         .rad_o  (rb_rad[j+1]),
         .rem_o  (rb_rem[j+1]),
         .root_o (rb_root[j+1])
      );
   end

   // Normalised offsets wait for the square roots.
   always_comb begin
      hold_in[0].east  = nh_a[5];
      hold_in[0].north = $signed(nh_b[5]);
      hold_in[0].up    = ns_a[5];
      for (int k = 1; k < 32; k++) begin
         hold_in[k] = hold_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 32; k++) begin
            hold_ff[k] <= hold_in[k];
         end
      end
   end

   // CORDIC start vectors; a negative north is turned through half a turn first.
   always_comb begin
      pn_x    = {{4{hold_ff[31].north[31]}}, hold_ff[31].north, 24'b0};
      pe_y    = {{4{hold_ff[31].east[31]}}, hold_ff[31].east, 24'b0};
      flip    = hold_ff[31].north[31];
      az_x_in = flip ? -pn_x : pn_x;
      az_y_in = flip ? -pe_y : pe_y;
      az_z_in = flip ? crae_pkg::HALF_TURN : '0;
      el_x_in = {4'b0, rb_root[32], 24'b0};
      el_y_in = {{4{hold_ff[31].up[31]}}, hold_ff[31].up, 24'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         az_x_ff <= az_x_in;
         az_y_ff <= az_y_in;
         az_z_ff <= az_z_in;
         el_x_ff <= el_x_in;
         el_y_ff <= el_y_in;
      end
   end

   assign az_x[0] = az_x_ff;
   assign az_y[0] = az_y_ff;
   assign az_z[0] = az_z_ff;
   assign el_x[0] = el_x_ff;
   assign el_y[0] = el_y_ff;
   assign el_z[0] = '0;

   for (genvar i = 0; i < NC; i++) begin : g_cordic
      crae_cordic_cell #(.SHIFT(i), .ATAN(crae_pkg::atan_bam(i))) u_cordic_az (
         .clock (clock),
         .en    (en),
         .x_i   (az_x[i]),
         .y_i   (az_y[i]),
         .z_i   (az_z[i]),
         .x_o   (az_x[i+1]),
         .y_o   (az_y[i+1]),
         .z_o   (az_z[i+1])
      );
      crae_cordic_cell #(.SHIFT(i), .ATAN(crae_pkg::atan_bam(i))) u_cordic_el (
         .clock (clock),
         .en    (en),
         .x_i   (el_x[i]),
         .y_i   (el_y[i]),
         .z_i   (el_z[i]),
         .x_o   (el_x[i+1]),
         .y_o   (el_y[i+1]),
         .z_o   (el_z[i+1])
      );
   end

   // Magnitude and sign of the elevation angle.
   assign abs_el_in = el_z[NC][31] ? (~el_z[NC] + 32'd1) : el_z[NC];

   always_ff @(posedge clock) begin
      if (en) begin
         abs_az_ff  <= az_z[NC];
         abs_el_ff  <= abs_el_in;
         abs_neg_ff <= el_z[NC][31];
      end
   end

   // Binary angle to degree units.
   assign mul_az_in = {25'b0, abs_az_ff} * {32'b0, crae_pkg::DEG_UNITS};
   assign mul_el_in = {25'b0, abs_el_ff} * {32'b0, crae_pkg::DEG_UNITS};

   always_ff @(posedge clock) begin
      if (en) begin
         mul_az_ff  <= mul_az_in;
         mul_el_ff  <= mul_el_in;
         mul_neg_ff <= abs_neg_ff;
      end
   end

   // Rounding, wrap, saturation and the special cases at the axes and the origin.
   always_comb begin
      az_round = {1'b0, mul_az_ff} + crae_pkg::HALF_STEP;
      el_round = {1'b0, mul_el_ff} + crae_pkg::HALF_STEP;
      az_val   = az_round[56:32];
      el_m     = el_round[56:32];
      el_cap   = (el_m > crae_pkg::ELEV_LIMIT) ? crae_pkg::ELEV_LIMIT : el_m;
      el_val   = mul_neg_ff ? -$signed(el_cap[23:0]) : $signed(el_cap[23:0]);
      if (side_ff[NUM_ST-1].h_zero || (az_val >= crae_pkg::DEG_UNITS)) begin
         az_val = '0;
      end
      if (side_ff[NUM_ST-1].s_zero) begin
         el_val = '0;
      end else if (side_ff[NUM_ST-1].h_zero) begin
         el_val = side_ff[NUM_ST-1].u_neg ? crae_pkg::EL_MIN : crae_pkg::EL_MAX;
      end
      res.range     = side_ff[NUM_ST-1].range;
      res.azimuth   = az_val;
      res.elevation = el_val;
      res.origin    = side_ff[NUM_ST-1].s_zero;
   end

   // Output register with a one-entry skid register behind it.
   always_comb begin
      tail_fire = en && valid_ff[NUM_ST-1];
      out_free  = !out_v_ff || !rsp_stall;
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (out_free) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = tail_fire;
            out_d_in = res;
         end
      end else if (tail_fire) begin
         skid_v_in = 1'b1;
         skid_d_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_range_cm        = out_d_ff.range;
   assign rsp_azimuth_angle   = out_d_ff.azimuth;
   assign rsp_elevation_angle = out_d_ff.elevation;
   assign rsp_at_origin       = out_d_ff.origin;

   // The skid register is only ever filled behind a held result.
   `CRAE_ASSERT_ALWAYS(a_skid_behind_out, !skid_v_ff || out_v_ff, "skid full with output empty")
   // A finished transaction arriving at a stalled output is caught in the skid register.
   `CRAE_ASSERT_NEXT(a_skid_catches, rsp_valid && rsp_stall && !skid_v_ff && valid_ff[NUM_ST-1], skid_v_ff, "finished transaction lost at stalled output")
   // The origin gives zero range and zero elevation.
   `CRAE_ASSERT_IMPLIES(a_origin_zero, rsp_valid && rsp_at_origin, (rsp_range_cm == '0) && (rsp_elevation_angle == '0), "origin result not zero")
   // Azimuth stays below a full turn.
   `CRAE_ASSERT_IMPLIES(a_az_wrapped, rsp_valid, rsp_azimuth_angle < crae_pkg::DEG_UNITS, "azimuth not wrapped")
   // Elevation stays within a quarter turn either side of the horizon.
   `CRAE_ASSERT_IMPLIES(a_el_limits, rsp_valid, (rsp_elevation_angle <= crae_pkg::EL_MAX) && (rsp_elevation_angle >= crae_pkg::EL_MIN), "elevation beyond limits")

endmodule

// ===== src/crae_norm_cell.sv =====
// One step of the normalising shift: moves a square up by a fixed number of bit pairs when it fits.
module crae_norm_cell #(
   parameter int PAIRS   = 1,
   parameter int B_W     = 32,
   parameter int B_SCALE = 1
) (
   input  logic               clock,
   input  logic               en,
   input  logic [63:0]        sq_i,
   input  logic signed [31:0] a_i,
   input  logic [B_W-1:0]     b_i,
   output logic [63:0]        sq_o,
   output logic signed [31:0] a_o,
   output logic [B_W-1:0]     b_o
);

   logic               take;
   logic [63:0]        sq_in, sq_ff;
   logic signed [31:0] a_in, a_ff;
   logic [B_W-1:0]     b_in, b_ff;

   // Shift only while the square stays below 2^62 afterwards.
   always_comb begin
      take  = (sq_i[63 -: 2*PAIRS+2] == '0);
      sq_in = take ? (sq_i << (2*PAIRS)) : sq_i;
      a_in  = take ? (a_i <<< PAIRS) : a_i;
      b_in  = take ? (b_i << (B_SCALE*PAIRS)) : b_i;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
         a_ff  <= a_in;
         b_ff  <= b_in;
      end
   end

   assign sq_o = sq_ff;
   assign a_o  = a_ff;
   assign b_o  = b_ff;

endmodule

// ===== src/crae_sqrt_cell.sv =====
// One digit of the restoring integer square root: two radicand bits in, one root bit out.
module crae_sqrt_cell (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad_i,
   input  logic [32:0] rem_i,
   input  logic [31:0] root_i,
   output logic [63:0] rad_o,
   output logic [32:0] rem_o,
   output logic [31:0] root_o
);

   logic [34:0] rem_sh, trial, diff;
   logic        fit;
   logic [63:0] rad_in, rad_ff;
   logic [32:0] rem_in, rem_ff;
   logic [31:0] root_in, root_ff;

   // Bring down the next bit pair and try to subtract 4*root+1.
   always_comb begin
      rem_sh  = {rem_i, rad_i[63:62]};
      trial   = {1'b0, root_i, 2'b01};
      fit     = (rem_sh >= trial);
      diff    = rem_sh - trial;
      rem_in  = fit ? diff[32:0] : rem_sh[32:0];
      root_in = {root_i[30:0], fit};
      rad_in  = rad_i << 2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

// ===== src/crae_cordic_cell.sv =====
// One vectoring micro-rotation of the CORDIC, driving y towards zero.
module crae_cordic_cell #(
   parameter int          SHIFT = 0,
   parameter logic [31:0] ATAN  = 32'd0
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [crae_pkg::CORDIC_W-1:0] x_i,
   input  logic signed [crae_pkg::CORDIC_W-1:0] y_i,
   input  logic [31:0]                         z_i,
   output logic signed [crae_pkg::CORDIC_W-1:0] x_o,
   output logic signed [crae_pkg::CORDIC_W-1:0] y_o,
   output logic [31:0]                         z_o
);

   logic signed [crae_pkg::CORDIC_W-1:0] xs, ys, x_in, y_in, x_ff, y_ff;
   logic [31:0]                          z_in, z_ff;
   logic                                 y_pos;

   // Rotate clockwise when y is above zero, otherwise anticlockwise.
   always_comb begin
      xs    = x_i >>> SHIFT;
      ys    = y_i >>> SHIFT;
      y_pos = !y_i[crae_pkg::CORDIC_W-1] && (y_i != '0);
      if (y_pos) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + ATAN;
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the offset to range, azimuth and elevation unit.
`timescale 1ns / 100ps

module testbench;

   localparam int STAGES = 24;
   localparam int LATENCY = 42 + STAGES;
   localparam int RANDOM_ITEMS = 450;

   typedef struct packed {
      logic signed [31:0] east;
      logic signed [31:0] north;
      logic signed [31:0] up;
   } offset_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_east_cm;
   logic signed [31:0] req_north_cm;
   logic signed [31:0] req_up_cm;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [31:0]        rsp_range_cm;
   logic [24:0]        rsp_azimuth_angle;
   logic signed [23:0] rsp_elevation_angle;
   logic               rsp_at_origin;

   offset_type offset_queue[$];
   crae_pkg::result_type expected_queue[$];
   int         error_count = 0;
   int         send_gap = 0;
   int         hold_off = 0;
   bit         stimulus_done = 0;
   bit         flush_wait = 0;

   cartesian_to_range_azimuth_elevation_unit #(.CORDIC_STAGES(STAGES)) dut (.*);

   // Clock generation.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Arctangent of 2^-i as a binary angle, kept apart from the design's table.
   function automatic logic [31:0] atan_step(input int i);
      logic [31:0] tab[0:39];
      tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
              10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
              41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
              10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      return tab[i];
   endfunction

   // Floor of the square root, bit by bit.
   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] op, res, one;
      op = v; res = 0; one = 64'd1 << 62;
      while (one > op) one >>= 2;
      while (one != 0) begin
         if (op >= res + one) begin
            op -= res + one;
            res = (res >> 1) + one;
         end else begin
            res >>= 1;
         end
         one >>= 2;
      end
      return res;
   endfunction

   // Largest k up to 31 keeping the squared length times 4^k below 2^62.
   function automatic int norm_bits(input logic [63:0] sq);
      int k;
      k = 0;
      while (k < 31 && (sq >> (60 - 2 * k)) == 0) k++;
      return k;
   endfunction

   // Vectoring rotation giving the binary angle of (x, y) from the +x axis.
   function automatic logic [31:0] bearing_bam(input logic signed [63:0] x0,
                                               input logic signed [63:0] y0);
      logic signed [63:0] x, y, xs, ys;
      logic [31:0] z;
      x = x0; y = y0; z = 0;
      if (x < 0) begin
         x = -x; y = -y; z = crae_pkg::HALF_TURN;
      end
      for (int i = 0; i < STAGES && i < 40; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + atan_step(i);
         end else begin
            x = x - ys; y = y + xs; z = z - atan_step(i);
         end
      end
      return z;
   endfunction

   // Expected range and angles of one offset.
   function automatic crae_pkg::result_type predict_polar(input offset_type o);
      crae_pkg::result_type r;
      logic signed [63:0] e, n, u, hs, us, zs;
      logic [63:0] h2, s2, mag, m, root;
      logic [95:0] prod;
      logic [31:0] z;
      int k;
      e = o.east; n = o.north; u = o.up;
      h2 = e * e + n * n;
      s2 = h2 + u * u;
      r = '0;
      root = root_floor(s2);
      r.range = root[31:0];
      if (h2 != 0) begin
         k = norm_bits(h2);
         z = bearing_bam(n <<< (k + 24), e <<< (k + 24));
         prod = (96'(z) * 96'(crae_pkg::DEG_UNITS) + 96'h8000_0000) >> 32;
         r.azimuth = (prod >= crae_pkg::DEG_UNITS) ? 25'd0 : prod[24:0];
      end
      if (s2 == 0) begin
         r.origin = 1'b1;
      end else if (h2 == 0) begin
         r.elevation = (u > 0) ? crae_pkg::EL_MAX : crae_pkg::EL_MIN;
      end else begin
         k = norm_bits(s2);
         hs = root_floor(h2 << (2 * k));
         us = u <<< k;
         z = bearing_bam(hs <<< 24, us <<< 24);
         zs = 64'(signed'(z));
         mag = (zs < 0) ? -zs : zs;
         m = (mag * 64'(crae_pkg::DEG_UNITS) + 64'h8000_0000) >> 32;
         if (m > crae_pkg::ELEV_LIMIT) m = 64'(crae_pkg::ELEV_LIMIT);
         r.elevation = (zs < 0) ? -24'(m) : 24'(m);
      end
      return r;
   endfunction

   function automatic int random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Random offset, mostly spread over every magnitude.
   function automatic logic signed [31:0] random_coord();
      int sh;
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 6) - 3;
         default: begin
            sh = $urandom_range(0, 31);
            return signed'($urandom) >>> sh;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: presents queued offsets, with random gaps and one drain pause.
   always @(posedge clock) begin
      offset_type o;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) send_gap = random_gap();
         if (flush_wait && expected_queue.size() != 0) begin
            req_valid <= 1'b0;
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (offset_queue.size() != 0) begin
            flush_wait = 0;
            o = offset_queue.pop_front();
            expected_queue.push_back(predict_polar(o));
            req_east_cm <= o.east;
            req_north_cm <= o.north;
            req_up_cm <= o.up;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compares every accepted result and drives random stalls.
   always @(posedge clock) begin
      crae_pkg::result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_queue.size() == 0) begin
               report_mismatch("unexpected result", 32'd1, 32'd0);
            end else begin
               want = expected_queue.pop_front();
               if (rsp_range_cm !== want.range)
                  report_mismatch("range_cm", rsp_range_cm, want.range);
               if (rsp_azimuth_angle !== want.azimuth)
                  report_mismatch("azimuth_angle", 32'(rsp_azimuth_angle),
                                  32'(want.azimuth));
               if (rsp_elevation_angle !== want.elevation)
                  report_mismatch("elevation_angle", 32'(rsp_elevation_angle),
                                  32'(want.elevation));
               if (rsp_at_origin !== want.origin)
                  report_mismatch("at_origin", 32'(rsp_at_origin), 32'(want.origin));
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_stall <= 1'b1;
         end else begin
            hold_off = random_gap();
            rsp_stall <= (hold_off > 0);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      offset_type o;
      logic signed [31:0] edges[6];
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_east_cm = '0;
      req_north_cm = '0;
      req_up_cm = '0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: origin, axes, diagonals, extremes and pure vertical offsets.
      edges = '{32'sh8000_0000, 32'sh7fff_ffff, -1, 1, 0, 1000};
      offset_queue.push_back('{0, 0, 0});
      offset_queue.push_back('{0, 0, 5});
      offset_queue.push_back('{0, 0, -5});
      offset_queue.push_back('{0, 0, 32'sh8000_0000});
      offset_queue.push_back('{0, 0, 32'sh7fff_ffff});
      offset_queue.push_back('{0, 100, 0});
      offset_queue.push_back('{100, 0, 0});
      offset_queue.push_back('{0, -100, 0});
      offset_queue.push_back('{-100, 0, 0});
      offset_queue.push_back('{-1, 1000000, 0});
      offset_queue.push_back('{7, 7, 7});
      offset_queue.push_back('{-7, -7, -7});
      offset_queue.push_back('{1, 0, 2147483647});
      for (int i = 0; i < 12; i++)
         offset_queue.push_back('{edges[i % 6], edges[(i + 1) % 6], edges[(i + 3) % 6]});

      // Random offsets, with one pause until the pipeline has drained.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         o.east = random_coord();
         o.north = random_coord();
         o.up = random_coord();
         offset_queue.push_back(o);
      end
      wait (offset_queue.size() < RANDOM_ITEMS / 2);
      flush_wait = 1;
      wait (offset_queue.size() == 0 && !(req_valid && req_stall));
      @(posedge clock);
      wait (expected_queue.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
